@@ hw/rtl/mwh_pkg.sv @@
// mwh_pkg: constants, command/status types and helper functions for the
// word-serial murmur 64-bit hash block. No dependencies.

package mwh_pkg;

    localparam logic [31:0] MUL_HI     = 32'hc6a4a793;
    localparam logic [31:0] MUL_LO     = 32'h5bd1e995;
    localparam int          FOLD_SHIFT = 47;
    localparam logic [63:0] SEED_RESET = 64'h00000000c70f6907;

    typedef logic [3:0] dp_op_t;

    localparam dp_op_t OP_NONE           = 4'd0;
    localparam dp_op_t OP_LOAD_LEN       = 4'd1;
    localparam dp_op_t OP_MUL_LL         = 4'd2;
    localparam dp_op_t OP_MUL_LH         = 4'd3;
    localparam dp_op_t OP_MUL_HL         = 4'd4;
    localparam dp_op_t OP_HASH_START     = 4'd5;
    localparam dp_op_t OP_LOAD_WORD      = 4'd6;
    localparam dp_op_t OP_LOAD_FOLD_ACC  = 4'd7;
    localparam dp_op_t OP_XOR_ACC        = 4'd8;
    localparam dp_op_t OP_XOR_TAIL       = 4'd9;
    localparam dp_op_t OP_HASH_FROM_ACC  = 4'd10;
    localparam dp_op_t OP_LOAD_FOLD_HASH = 4'd11;
    localparam dp_op_t OP_OUT            = 4'd12;

    typedef struct packed {
        logic   capture;
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic first;
        logic last;
        logic count_full;
        logic count_nz;
        logic out_busy;
    } dp_status_t;

    // v ^ (v >> 47)
    function automatic logic [63:0] fold64(input logic [63:0] v);
        fold64 = v ^ (v >> FOLD_SHIFT);
    endfunction

    // keeps the low n bytes of a tail word
    function automatic logic [63:0] tail_mask(input logic [2:0] n);
        case (n)
            3'd1:    tail_mask = 64'h00000000000000ff;
            3'd2:    tail_mask = 64'h000000000000ffff;
            3'd3:    tail_mask = 64'h0000000000ffffff;
            3'd4:    tail_mask = 64'h00000000ffffffff;
            3'd5:    tail_mask = 64'h000000ffffffffff;
            3'd6:    tail_mask = 64'h0000ffffffffffff;
            3'd7:    tail_mask = 64'h00ffffffffffffff;
            default: tail_mask = 64'h0000000000000000;
        endcase
    endfunction

endpackage

@@ hw/rtl/mwh_datapath.sv @@
// mwh_datapath: input capture, seed, running hash, shared 32x32 multiplier
// and output register. Depends on mwh_pkg; driven by mwh_ctrl commands.

module mwh_datapath import mwh_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [63:0] cfg_wr_data,
    input  logic [63:0] s_data_word,
    input  logic [3:0]  s_byte_count,
    input  logic        s_first_word,
    input  logic        s_last_word,
    input  logic [31:0] s_message_length,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_hash_value
);

    logic [63:0] seed_reg;
    logic [63:0] word_reg;
    logic [3:0]  count_reg;
    logic        first_reg;
    logic        last_reg;
    logic [31:0] length_reg;
    logic [63:0] hash_reg,  hash_next;
    logic [63:0] opa_reg,   opa_next;
    logic [63:0] acc_reg,   acc_next;
    logic        m_valid_reg, m_valid_next;
    logic [63:0] m_hash_reg,  m_hash_next;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;

    // one 32x32 product per cycle, three passes give a 64-bit product mod 2^64
    always_comb begin
        case (cmd.op)
            OP_MUL_LH: begin
                mul_a = opa_reg[31:0];
                mul_b = MUL_HI;
            end
            OP_MUL_HL: begin
                mul_a = opa_reg[63:32];
                mul_b = MUL_LO;
            end
            default: begin
                mul_a = opa_reg[31:0];
                mul_b = MUL_LO;
            end
        endcase
        mul_p = {32'd0, mul_a} * {32'd0, mul_b};
    end

    always_comb begin
        hash_next    = hash_reg;
        opa_next     = opa_reg;
        acc_next     = acc_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        m_hash_next  = m_hash_reg;
        case (cmd.op)
            OP_LOAD_LEN:       opa_next  = {32'd0, length_reg};
            OP_MUL_LL:         acc_next  = mul_p;
            OP_MUL_LH,
            OP_MUL_HL:         acc_next  = acc_reg + {mul_p[31:0], 32'd0};
            OP_HASH_START:     hash_next = seed_reg ^ acc_reg;
            OP_LOAD_WORD:      opa_next  = word_reg;
            OP_LOAD_FOLD_ACC:  opa_next  = fold64(acc_reg);
            OP_XOR_ACC:        opa_next  = hash_reg ^ acc_reg;
            OP_XOR_TAIL:       opa_next  = hash_reg ^ (word_reg & tail_mask(count_reg[2:0]));
            OP_HASH_FROM_ACC:  hash_next = acc_reg;
            OP_LOAD_FOLD_HASH: opa_next  = fold64(hash_reg);
            OP_OUT: begin
                m_valid_next = 1'b1;
                m_hash_next  = fold64(acc_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg    <= SEED_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                seed_reg <= cfg_wr_data;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            word_reg   <= s_data_word;
            count_reg  <= s_byte_count;
            first_reg  <= s_first_word;
            last_reg   <= s_last_word;
            length_reg <= s_message_length;
        end
        hash_reg   <= hash_next;
        opa_reg    <= opa_next;
        acc_reg    <= acc_next;
        m_hash_reg <= m_hash_next;
    end

    // counts above eight saturate to a full word
    assign status.first      = first_reg;
    assign status.last       = last_reg;
    assign status.count_full = count_reg[3];
    assign status.count_nz   = (count_reg != 4'd0);
    assign status.out_busy   = m_valid_reg & ~m_ready;

    assign m_valid      = m_valid_reg;
    assign m_hash_value = m_hash_reg;

endmodule

@@ hw/rtl/mwh_ctrl.sv @@
// mwh_ctrl: sequencer for the murmur hash datapath, including the
// three-pass multiply loop. Depends on mwh_pkg.

module mwh_ctrl import mwh_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_DECIDE  = 4'd1;
    localparam logic [3:0] ST_MUL     = 4'd2;
    localparam logic [3:0] ST_START   = 4'd3;
    localparam logic [3:0] ST_BODY    = 4'd4;
    localparam logic [3:0] ST_WFOLD   = 4'd5;
    localparam logic [3:0] ST_WXOR    = 4'd6;
    localparam logic [3:0] ST_BACK    = 4'd7;
    localparam logic [3:0] ST_CHKLAST = 4'd8;
    localparam logic [3:0] ST_FIN     = 4'd9;

    logic [3:0] state_reg,  state_next;
    logic [3:0] ret_reg,    ret_next;
    logic [1:0] step_reg,   step_next;
    logic       in_msg_reg, in_msg_next;

    always_comb begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        step_next   = step_reg;
        in_msg_next = in_msg_reg;
        cmd.capture = 1'b0;
        cmd.op      = OP_NONE;
        s_ready     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (status.first) begin
                    cmd.op     = OP_LOAD_LEN;
                    ret_next   = ST_START;
                    state_next = ST_MUL;
                end else if (!in_msg_reg) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_BODY;
                end
            end
            ST_MUL: begin
                case (step_reg)
                    2'd0:    cmd.op = OP_MUL_LL;
                    2'd1:    cmd.op = OP_MUL_LH;
                    default: cmd.op = OP_MUL_HL;
                endcase
                if (step_reg == 2'd2) begin
                    step_next  = 2'd0;
                    state_next = ret_reg;
                end else begin
                    step_next = step_reg + 2'd1;
                end
            end
            ST_START: begin
                cmd.op      = OP_HASH_START;
                in_msg_next = 1'b1;
                state_next  = ST_BODY;
            end
            ST_BODY: begin
                if (status.count_full) begin
                    cmd.op     = OP_LOAD_WORD;
                    ret_next   = ST_WFOLD;
                    state_next = ST_MUL;
                end else if (status.count_nz) begin
                    cmd.op     = OP_XOR_TAIL;
                    ret_next   = ST_BACK;
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_CHKLAST;
                end
            end
            ST_WFOLD: begin
                cmd.op     = OP_LOAD_FOLD_ACC;
                ret_next   = ST_WXOR;
                state_next = ST_MUL;
            end
            ST_WXOR: begin
                cmd.op     = OP_XOR_ACC;
                ret_next   = ST_BACK;
                state_next = ST_MUL;
            end
            ST_BACK: begin
                cmd.op     = OP_HASH_FROM_ACC;
                state_next = ST_CHKLAST;
            end
            ST_CHKLAST: begin
                if (status.last) begin
                    cmd.op      = OP_LOAD_FOLD_HASH;
                    in_msg_next = 1'b0;
                    ret_next    = ST_FIN;
                    state_next  = ST_MUL;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_FIN: begin
                if (!status.out_busy) begin
                    cmd.op     = OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            ret_reg    <= ST_IDLE;
            step_reg   <= 2'd0;
            in_msg_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            step_reg   <= step_next;
            in_msg_reg <= in_msg_next;
        end
    end

endmodule

@@ hw/rtl/murmur64_word_hash.sv @@
// murmur64_word_hash: top level of the word-serial 64-bit murmur hash.
// Depends on mwh_pkg, mwh_ctrl and mwh_datapath.

// Hashes a message delivered as little-endian 64-bit words, one word per
// transfer on the s_ channel; the first word of a message carries the total
// byte length and the last word triggers the final mix and one hash transfer
// on the m_ channel. Words are processed one at a time: s_ready stays low from
// a word's transfer until the block is through with that word. The work per
// word is set by the single 32x32 multiplier, which forms each 64-bit product
// (mod 2^64) in three passes; a full word needs three such products in a
// chain, a tail word one, and the first and the last word one more each. A
// finished hash sits in the output register while the next message is taken
// in; only the final output step waits if that register is still occupied.
// The seed is written through cfg_wr_en and cfg_wr_data and applies from the
// next first word on.

module murmur64_word_hash import mwh_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // seed register write
    input  logic        cfg_wr_en,
    input  logic [63:0] cfg_wr_data,
    // word input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_data_word,
    input  logic [3:0]  s_byte_count,
    input  logic        s_first_word,
    input  logic        s_last_word,
    input  logic [31:0] s_message_length,
    // hash output
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_hash_value
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer: accepts a word, walks the multiply chain, issues the result
    mwh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // datapath: captured word, running hash, multiplier and output register
    mwh_datapath u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_data_word      (s_data_word),
        .s_byte_count     (s_byte_count),
        .s_first_word     (s_first_word),
        .s_last_word      (s_last_word),
        .s_message_length (s_message_length),
        .cmd              (cmd),
        .status           (status),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_hash_value     (m_hash_value)
    );

endmodule

@@ hw/rtl/mwh_checker.sv @@
// mwh_checker: port-level assertions for murmur64_word_hash, bound to the
// top level below. No package dependency.

module mwh_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [63:0] m_hash_value
);

    // held result stays put until its transfer
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hash_value))
        else $error("result changed while stalled");

    // one word at a time: input closes right after a transfer
    a_busy_after_in: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input still open after a transfer");

    // a result appears only at the end of word processing
    a_out_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result raised while idle");

    // reset leaves the block empty and ready
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("bad state after reset");

endmodule

bind murmur64_word_hash mwh_checker u_mwh_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_hash_value (m_hash_value)
);

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// testbench: self-checking regression for murmur64_word_hash with its own hash predictor,
// random valid/ready idling on both channels, and seed register changes between phases.
// Depends on mwh_pkg and the murmur64_word_hash rtl.

module testbench;
    import mwh_pkg::*;

    localparam logic [63:0] HASH_MUL      = {MUL_HI, MUL_LO};
    localparam int          SETTLE_CYCLES = 40;     // covers the slowest word the block takes
    localparam int          HOLD_CYCLES   = 600;    // long receiver hold-off
    localparam int          MAX_REPORTS   = 100;

    logic        aclk             = 1'b0;
    logic        aresetn          = 1'b0;
    logic        cfg_wr_en        = 1'b0;
    logic [63:0] cfg_wr_data      = '0;
    logic        s_valid          = 1'b0;
    logic        s_ready;
    logic [63:0] s_data_word      = '0;
    logic [3:0]  s_byte_count     = '0;
    logic        s_first_word     = 1'b0;
    logic        s_last_word      = 1'b0;
    logic [31:0] s_message_length = '0;
    logic        m_valid;
    logic        m_ready          = 1'b0;
    logic [63:0] m_hash_value;

    // predictor state
    logic [63:0] seed_model  = SEED_RESET;
    logic [63:0] run_hash    = '0;
    bit          msg_open    = 1'b0;
    logic [63:0] hash_q[$];
    logic [63:0] want_hash;

    int unsigned words_taken    = 0;
    int unsigned mismatch_count = 0;
    bit          no_gaps        = 1'b0;
    bit          hold_req       = 1'b0;

    murmur64_word_hash u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_word      (s_data_word),
        .s_byte_count     (s_byte_count),
        .s_first_word     (s_first_word),
        .s_last_word      (s_last_word),
        .s_message_length (s_message_length),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_hash_value     (m_hash_value)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ---------------------------------------------------------------- helpers

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int unsigned r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // message size: mostly short keys, a few long ones
    function automatic int unsigned pick_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 24);
        if (r < 95) return $urandom_range(25, 80);
        return $urandom_range(81, 320);
    endfunction

    // v xor its top 17 bits brought down
    function automatic logic [63:0] spread_high(input logic [63:0] v);
        return v ^ (v >> FOLD_SHIFT);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t ns: hash mismatch: %s", $time, msg);
    endtask

    // advance the hash predictor by one accepted word
    task automatic absorb_word(input logic [63:0] word, input logic [3:0] count,
                               input logic first, input logic last,
                               input logic [31:0] length);
        logic [63:0] k;
        logic [3:0]  n;
        if (first) begin
            run_hash = seed_model ^ ({32'd0, length} * HASH_MUL);
            msg_open = 1'b1;
        end else if (!msg_open) begin
            return;     // stray word, dropped by the block
        end
        words_taken++;
        n = (count > 4'd8) ? 4'd8 : count;
        if (n == 4'd8) begin
            k = spread_high(word * HASH_MUL) * HASH_MUL;
            run_hash = (run_hash ^ k) * HASH_MUL;
        end else if (n != 4'd0) begin
            k = word & ((64'd1 << (n * 8)) - 64'd1);
            run_hash = (run_hash ^ k) * HASH_MUL;
        end
        if (last) begin
            k = spread_high(spread_high(run_hash) * HASH_MUL);
            hash_q.push_back(k);
            msg_open = 1'b0;
        end
    endtask

    // one word transfer on the s_ channel; valid stays up if the next word follows at once
    task automatic send_word(input logic [63:0] word, input logic [3:0] count,
                             input logic first, input logic last,
                             input logic [31:0] length);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_data_word      <= word;
        s_byte_count     <= count;
        s_first_word     <= first;
        s_last_word      <= last;
        s_message_length <= length;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        absorb_word(word, count, first, last, length);
    endtask

    // split nbytes into words; open_end leaves the message without a last word
    task automatic send_message(input int unsigned nbytes, input logic [31:0] len_field,
                                input bit open_end);
        int unsigned words;
        int unsigned left;
        logic [3:0]  cnt;
        words = (nbytes + 7) / 8;
        if (words == 0) begin
            send_word(rand64(), 4'd0, 1'b1, !open_end, len_field);
            return;
        end
        left = nbytes;
        for (int i = 0; i < words; i++) begin
            cnt = (left >= 8) ? 4'd8 : 4'(left);
            // length is ignored past the first word, so it gets noise there
            send_word(rand64(), cnt, i == 0, !open_end && (i == words - 1),
                      (i == 0) ? len_field : $urandom);
            left -= cnt;
        end
    endtask

    // drop valid, wait for every hash to come out, then let the datapath settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (hash_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_seed(input logic [63:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        seed_model = value;
    endtask

    // ---------------------------------------------------------------- tests

    // field extremes and the special cases, with the reset seed
    task automatic test_corner_words();
        // stray word before any message opens
        send_word('1, 4'd8, 1'b0, 1'b1, '1);
        // empty messages, one claiming the largest length
        send_word('0, 4'd0, 1'b1, 1'b1, 32'd0);
        send_word('1, 4'd0, 1'b1, 1'b1, '1);
        // single full words
        send_word('1, 4'd8, 1'b1, 1'b1, 32'd8);
        send_word('0, 4'd8, 1'b1, 1'b1, 32'd8);
        // tails of one and seven bytes, upper bytes must be masked
        send_word('1, 4'd1, 1'b1, 1'b1, 32'd1);
        send_word('1, 4'd7, 1'b1, 1'b1, 32'd7);
        // byte counts above eight saturate to a full word
        send_word(64'h0123456789abcdef, 4'd9, 1'b1, 1'b1, 32'd9);
        send_word(64'hfedcba9876543210, 4'd15, 1'b1, 1'b1, 32'd15);
        // zero count in the middle of a message
        send_word(rand64(), 4'd8, 1'b1, 1'b0, 32'd11);
        send_word('1, 4'd0, 1'b0, 1'b0, '1);
        send_word(rand64(), 4'd3, 1'b0, 1'b1, 32'd0);
        // short word that is not last
        send_word('1, 4'd5, 1'b1, 1'b0, 32'd13);
        send_word(rand64(), 4'd8, 1'b0, 1'b1, 32'd0);
        // restart drops the open message
        send_word(rand64(), 4'd8, 1'b1, 1'b0, 32'd40);
        send_word(rand64(), 4'd8, 1'b1, 1'b1, 32'd8);
        // length field disagreeing with the bytes sent
        send_word(rand64(), 4'd8, 1'b1, 1'b0, 32'd3);
        send_word(rand64(), 4'd8, 1'b0, 1'b1, 32'd3);
        // last word carrying no bytes
        send_word(rand64(), 4'd4, 1'b1, 1'b0, 32'd4);
        send_word(rand64(), 4'd0, 1'b0, 1'b1, 32'd4);
        // stray after a closed message
        send_word(rand64(), 4'd8, 1'b0, 1'b0, 32'd8);
    endtask

    // seed extremes plus one random seed
    task automatic test_seed_settings();
        logic [63:0] seeds[3];
        seeds[0] = '0;
        seeds[1] = '1;
        seeds[2] = rand64();
        foreach (seeds[i]) begin
            write_seed(seeds[i]);
            send_word(rand64(), 4'd0, 1'b1, 1'b1, 32'd0);
            send_word('1, 4'd8, 1'b1, 1'b1, 32'd8);
            send_message(20, 20, 1'b0);
        end
    endtask

    // mostly well-formed messages with random content, some broken traffic mixed in
    task automatic test_random_traffic();
        int unsigned phase_end;
        int unsigned r;
        int unsigned n;
        int unsigned nw;
        for (int phase = 0; phase < 4; phase++) begin
            write_seed((phase == 3) ? SEED_RESET : rand64());
            phase_end = words_taken + 275;
            while (words_taken < phase_end) begin
                r = $urandom_range(0, 99);
                n = pick_length();
                if (r < 78) begin
                    send_message(n, n, 1'b0);
                end else if (r < 84) begin
                    // abandoned, the next first word restarts
                    send_message($urandom_range(1, 40), n, 1'b1);
                end else if (r < 90) begin
                    send_word(rand64(), 4'($urandom_range(0, 15)), 1'($urandom),
                              1'($urandom), $urandom);
                end else if (r < 95) begin
                    send_message(n, $urandom, 1'b0);
                end else begin
                    // any byte counts, zero and oversized among them
                    nw = $urandom_range(1, 5);
                    for (int i = 0; i < nw; i++)
                        send_word(rand64(), 4'($urandom_range(0, 15)), i == 0,
                                  i == nw - 1, $urandom);
                end
            end
        end
    endtask

    // no idling on either side
    task automatic test_back_to_back();
        int unsigned n;
        no_gaps = 1'b1;
        repeat (40) begin
            n = $urandom_range(0, 24);
            send_message(n, n, 1'b0);
        end
        wait_idle();
        no_gaps = 1'b0;
    endtask

    // receiver holds off long enough that the output register fills and s_ready drops
    task automatic test_output_backpressure();
        int unsigned n;
        hold_req = 1'b1;
        repeat (80) begin
            n = $urandom_range(0, 16);
            send_message(n, n, 1'b0);
        end
    endtask

    // ---------------------------------------------------------------- processes

    // result sink: random m_ready with short and long stalls, plus the long hold-off
    initial begin : result_sink
        int stall;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            stall = pick_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    // every m_ transfer against the oldest predicted hash
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (hash_q.size() == 0) begin
                report_mismatch($sformatf("unexpected hash %h", m_hash_value));
            end else begin
                want_hash = hash_q.pop_front();
                if (m_hash_value !== want_hash)
                    report_mismatch($sformatf("hash_value %h, predicted %h",
                                              m_hash_value, want_hash));
            end
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_corner_words();
        test_seed_settings();
        test_random_traffic();
        test_back_to_back();
        test_output_backpressure();
        wait_idle();
        if (mismatch_count == 0)
            $display("murmur64_word_hash regression: pass");
        else
            $display("murmur64_word_hash regression: fail");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("murmur64_word_hash regression: fail");
        $finish;
    end

endmodule
